// ----- hdl/tldt_pkg.sv -----
// Package for the talker level dominance tracker.
// Holds field widths, stream layout, action codes and the controller/datapath
// command and status structs. No dependencies.
`default_nettype none

package tldt_pkg;

    localparam int TALKER_W   = 6;
    localparam int SAMPLE_W   = 16;
    localparam int LEVEL_W    = 17;
    localparam int OUT_W      = 16;
    localparam int FRAC_W     = 15;
    localparam int DVD_W      = 32;
    localparam int DVS_W      = 16;
    localparam int DIV_STEPS  = 32;
    localparam int DIV_CNT_W  = 5;
    localparam int QLOW_W     = 18;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 24;

    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_QUERY  = 1'b1;

    typedef struct packed {
        logic accept;
        logic mean_load;
        logic q_load;
        logic div_step;
        logic frame_finish;
        logic idx_clear;
        logic mine_load;
        logic scan_issue;
        logic clear_write;
        logic query_finish;
        logic rd_scan;
    } cmd_t;

    typedef struct packed {
        logic in_query;
        logic in_last;
        logic div_last;
        logic idx_last;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

// ----- hdl/talker_level_dominance_tracker_top.sv -----
// Top level of the talker level dominance tracker.
// Joins the controller and the datapath. Depends on tldt_pkg, tldt_ctrl, tldt_dp.
//
//   channel  dir  tdata (lsb up)                      tuser       tlast
//   s_       in   talker[5:0], sample[21:6], pad      action      frame_end
//   m_       out  level[15:0], is_loudest[16], pad    from_query  -
//
// A sample that does not close a frame leaves s_tready high for the next sample.
// A frame end runs two 32-step passes of the shared divider.
// A query walks the level table through its one read port.
// After reset a clearing pass writes every table entry, with s_tready low.
// A result waits in the output register; sample transfers continue behind it.
`default_nettype none

module talker_level_dominance_tracker_top #(
    parameter int TALKERS   = 64,
    parameter int MAX_FRAME = 1024
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [tldt_pkg::S_TDATA_W-1:0] s_tdata,  // talker, sample, zero pad
    input  wire logic                           s_tuser,  // action
    input  wire logic                           s_tlast,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [tldt_pkg::M_TDATA_W-1:0] m_tdata,  // level, is_loudest, zero pad
    output logic                                m_tuser   // from_query
);

    tldt_pkg::cmd_t cmd;
    tldt_pkg::sts_t sts;

    tldt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tldt_dp #(
        .TALKERS   (TALKERS),
        .MAX_FRAME (MAX_FRAME)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

// ----- hdl/tldt_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module tldt_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- hdl/tldt_dp.sv -----
// Datapath of the talker level dominance tracker: frame accumulators, top level,
// shared restoring divider, level table RAM, scan compare and output register.
// Depends on tldt_pkg and tldt_ram.
`default_nettype none

module tldt_dp #(
    parameter int TALKERS   = 64,
    parameter int MAX_FRAME = 1024
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire tldt_pkg::cmd_t                    cmd,
    output tldt_pkg::sts_t                         sts,
    input  wire logic [tldt_pkg::S_TDATA_W-1:0]    s_tdata,
    input  wire logic                              s_tuser,
    input  wire logic                              s_tlast,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [tldt_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                                   m_tuser
);

    localparam int ADDR_W = $clog2(TALKERS);
    localparam int CNT_W  = $clog2(MAX_FRAME + 1);
    localparam int SUM_W  = tldt_pkg::SAMPLE_W + $clog2(MAX_FRAME);
    localparam logic [31:0] TALKERS_U = 32'(TALKERS);
    localparam int PAD_W  = tldt_pkg::M_TDATA_W - tldt_pkg::OUT_W - 1;

    logic [tldt_pkg::TALKER_W-1:0]  in_talker;
    logic signed [tldt_pkg::SAMPLE_W-1:0] in_sample;
    logic [tldt_pkg::SAMPLE_W-1:0]  in_mag;

    logic [tldt_pkg::SAMPLE_W-1:0]  peak_reg;
    logic signed [SUM_W-1:0]        sum_reg;
    logic [CNT_W-1:0]               cnt_reg;
    logic [tldt_pkg::DVS_W-1:0]     top_reg;
    logic [tldt_pkg::TALKER_W-1:0]  who_reg;
    logic                           in_table_reg;
    logic [ADDR_W-1:0]              who_addr;

    logic [tldt_pkg::DVS_W-1:0]     rem_reg;
    logic [tldt_pkg::DVD_W-1:0]     quo_reg;
    logic [tldt_pkg::DVS_W-1:0]     dvs_reg;
    logic [tldt_pkg::DIV_CNT_W-1:0] div_cnt_reg;
    logic [tldt_pkg::DVS_W:0]       div_shift;
    logic [tldt_pkg::DVS_W+1:0]     div_trial;

    logic [SUM_W-1:0]               sum_mag;
    logic [tldt_pkg::LEVEL_W:0]     diff_wide;
    logic [tldt_pkg::LEVEL_W-1:0]   mean_mag;
    logic [tldt_pkg::LEVEL_W-1:0]   old_reg;
    logic [tldt_pkg::QLOW_W:0]      fresh_sum;
    logic [tldt_pkg::LEVEL_W-1:0]   fresh;

    logic [ADDR_W-1:0]              idx_reg;
    logic                           cmp_valid_reg;
    logic [ADDR_W-1:0]              cmp_idx_reg;
    logic [tldt_pkg::LEVEL_W-1:0]   mine_reg;
    logic                           loud_reg;

    logic                           ram_we;
    logic [ADDR_W-1:0]              ram_waddr;
    logic [tldt_pkg::LEVEL_W-1:0]   ram_wdata;
    logic [ADDR_W-1:0]              ram_raddr;
    logic [tldt_pkg::LEVEL_W-1:0]   ram_rdata;

    logic                           m_valid_reg;
    logic [tldt_pkg::OUT_W-1:0]     m_level_reg;
    logic                           m_loud_reg;
    logic                           m_query_reg;

    assign in_talker = s_tdata[tldt_pkg::TALKER_W-1:0];
    assign in_sample = $signed(s_tdata[tldt_pkg::TALKER_W +: tldt_pkg::SAMPLE_W]);
    assign in_mag    = in_sample[tldt_pkg::SAMPLE_W-1]
                       ? (~in_sample + tldt_pkg::SAMPLE_W'(1)) : in_sample;
    assign who_addr  = ADDR_W'(who_reg);

    assign sum_mag   = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign mean_mag  = quo_reg[tldt_pkg::LEVEL_W-1:0];
    assign diff_wide = sum_reg[SUM_W-1]
                       ? ({2'b00, peak_reg} + {1'b0, mean_mag})
                       : ({2'b00, peak_reg} - {1'b0, mean_mag});

    assign div_shift = {rem_reg, quo_reg[tldt_pkg::DVD_W-1]};
    assign div_trial = {1'b0, div_shift} - {2'b00, dvs_reg};

    assign fresh_sum = {2'b00, old_reg} + {1'b0, quo_reg[tldt_pkg::QLOW_W-1:0]};
    assign fresh     = fresh_sum[tldt_pkg::LEVEL_W:1];

    assign sts.in_query = (s_tuser == tldt_pkg::ACT_QUERY);
    assign sts.in_last  = s_tlast || (cnt_reg == CNT_W'(MAX_FRAME - 1));
    assign sts.div_last = (div_cnt_reg == tldt_pkg::DIV_CNT_W'(tldt_pkg::DIV_STEPS - 1));
    assign sts.idx_last = (idx_reg == ADDR_W'(TALKERS - 1));
    assign sts.out_free = !m_valid_reg || m_tready;

    assign ram_we    = cmd.clear_write || (cmd.frame_finish && in_table_reg);
    assign ram_waddr = cmd.clear_write ? idx_reg : who_addr;
    assign ram_wdata = cmd.clear_write ? '0 : fresh;
    assign ram_raddr = cmd.rd_scan ? idx_reg : who_addr;

    tldt_ram #(
        .WIDTH (tldt_pkg::LEVEL_W),
        .DEPTH (TALKERS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // frame accumulators and top level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            peak_reg <= '0;
            sum_reg  <= '0;
            cnt_reg  <= '0;
            top_reg  <= tldt_pkg::DVS_W'(1);
        end else if (cmd.frame_finish) begin
            peak_reg <= '0;
            sum_reg  <= '0;
            cnt_reg  <= '0;
        end else if (cmd.accept && !sts.in_query) begin
            sum_reg <= sum_reg + SUM_W'(in_sample);
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (in_mag > peak_reg) begin
                peak_reg <= in_mag;
            end
        end else if (cmd.mean_load && (peak_reg > top_reg)) begin
            top_reg <= peak_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            who_reg      <= in_talker;
            in_table_reg <= (32'(in_talker) < TALKERS_U);
        end
    end

    // shared restoring divider, one quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (cmd.mean_load) begin
            rem_reg     <= '0;
            quo_reg     <= tldt_pkg::DVD_W'(sum_mag);
            dvs_reg     <= tldt_pkg::DVS_W'(cnt_reg);
            div_cnt_reg <= '0;
        end else if (cmd.q_load) begin
            rem_reg     <= '0;
            quo_reg     <= {diff_wide[tldt_pkg::LEVEL_W-1:0], tldt_pkg::FRAC_W'(0)};
            dvs_reg     <= (peak_reg > top_reg) ? peak_reg : top_reg;
            div_cnt_reg <= '0;
        end else if (cmd.div_step) begin
            div_cnt_reg <= div_cnt_reg + tldt_pkg::DIV_CNT_W'(1);
            if (!div_trial[tldt_pkg::DVS_W+1]) begin
                rem_reg <= div_trial[tldt_pkg::DVS_W-1:0];
                quo_reg <= {quo_reg[tldt_pkg::DVD_W-2:0], 1'b1};
            end else begin
                rem_reg <= div_shift[tldt_pkg::DVS_W-1:0];
                quo_reg <= {quo_reg[tldt_pkg::DVD_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.q_load) begin
            old_reg <= in_table_reg ? ram_rdata : '0;
        end
    end

    // table walk index, shared by the clearing pass and the query scan
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg       <= '0;
            cmp_valid_reg <= 1'b0;
        end else begin
            cmp_valid_reg <= cmd.scan_issue;
            if (cmd.idx_clear) begin
                idx_reg <= '0;
            end else if (cmd.scan_issue || cmd.clear_write) begin
                idx_reg <= idx_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmp_idx_reg <= idx_reg;
        if (cmd.mine_load) begin
            mine_reg <= in_table_reg ? ram_rdata : '0;
            loud_reg <= in_table_reg && (ram_rdata != '0);
        end else if (cmp_valid_reg && (cmp_idx_reg != who_addr)
                     && (ram_rdata > mine_reg)) begin
            loud_reg <= 1'b0;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.frame_finish || cmd.query_finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.frame_finish) begin
            m_level_reg <= fresh[tldt_pkg::OUT_W] ? '1 : fresh[tldt_pkg::OUT_W-1:0];
            m_loud_reg  <= 1'b0;
            m_query_reg <= 1'b0;
        end else if (cmd.query_finish) begin
            m_level_reg <= mine_reg[tldt_pkg::OUT_W] ? '1 : mine_reg[tldt_pkg::OUT_W-1:0];
            m_loud_reg  <= loud_reg;
            m_query_reg <= 1'b1;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {PAD_W'(0), m_loud_reg, m_level_reg};
    assign m_tuser  = m_query_reg;

`ifndef SYNTHESIS
    a_top_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        top_reg != '0)
        else $error("top level reached zero");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_FRAME))
        else $error("frame count beyond frame limit");

    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.frame_finish || cmd.query_finish) |-> (!m_valid_reg || m_tready))
        else $error("result loaded over a pending transfer");

    a_mean_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.q_load |-> (quo_reg[tldt_pkg::DVD_W-1:tldt_pkg::LEVEL_W] == '0))
        else $error("frame mean exceeds peak range");
`endif

endmodule

`default_nettype wire

// ----- hdl/tldt_ctrl.sv -----
// Controller of the talker level dominance tracker: sequences the clearing
// pass, frame-end divisions and query scan. Depends on tldt_pkg.
`default_nettype none

module tldt_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire tldt_pkg::sts_t sts,
    output tldt_pkg::cmd_t      cmd
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MEAN_LOAD,
        ST_MEAN_DIV,
        ST_Q_LOAD,
        ST_Q_DIV,
        ST_FRAME_OUT,
        ST_QRY_READ,
        ST_QRY_MINE,
        ST_QRY_SCAN,
        ST_QRY_TAIL,
        ST_QRY_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_write = 1'b1;
                if (sts.idx_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid && ready_reg) begin
                    cmd.accept = 1'b1;
                    if (sts.in_query) begin
                        state_next = ST_QRY_READ;
                    end else if (sts.in_last) begin
                        state_next = ST_MEAN_LOAD;
                    end
                end
            end
            ST_MEAN_LOAD: begin
                cmd.mean_load = 1'b1;
                state_next    = ST_MEAN_DIV;
            end
            ST_MEAN_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_Q_LOAD;
                end
            end
            ST_Q_LOAD: begin
                cmd.q_load = 1'b1;
                state_next = ST_Q_DIV;
            end
            ST_Q_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_FRAME_OUT;
                end
            end
            ST_FRAME_OUT: begin
                if (sts.out_free) begin
                    cmd.frame_finish = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            ST_QRY_READ: begin
                cmd.idx_clear = 1'b1;
                state_next    = ST_QRY_MINE;
            end
            ST_QRY_MINE: begin
                cmd.mine_load = 1'b1;
                state_next    = ST_QRY_SCAN;
            end
            ST_QRY_SCAN: begin
                cmd.rd_scan    = 1'b1;
                cmd.scan_issue = 1'b1;
                if (sts.idx_last) begin
                    state_next = ST_QRY_TAIL;
                end
            end
            ST_QRY_TAIL: begin
                state_next = ST_QRY_OUT;
            end
            ST_QRY_OUT: begin
                if (sts.out_free) begin
                    cmd.query_finish = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            ready_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ready_reg <= (state_next == ST_IDLE);
        end
    end

    assign s_tready = ready_reg;

endmodule

`default_nettype wire
